// ===== rtl/core/trie_pkg.sv =====
// Shared types, constants and sizes for the array trie block.
// Used by every module under rtl/core but trie_ram; depends on nothing else.
package trie_pkg;

  // Sizing of the node table and the letter alphabet.
  localparam int unsigned NODES       = 4096;
  localparam int unsigned ALPHABET    = 26;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned NODE_W      = $clog2(NODES);
  localparam int unsigned SYM_IDX_W   = $clog2(ALPHABET);
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SYMBOL_W    = 5;
  localparam int unsigned PCOUNT_W    = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_INSERT = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_SEARCH = KIND_W'(1);

  // Fixed node numbers and limits.
  localparam logic [NODE_W-1:0]     ROOT_NODE = NODE_W'(1);
  localparam logic [NODE_W-1:0]     LAST_FREE = NODE_W'(NODES - 2);
  localparam logic [NODE_W-1:0]     LAST_ROW  = NODE_W'(NODES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Input and result beats.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SYMBOL_W-1:0] symbol;
    logic                has_symbol;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [PCOUNT_W-1:0] prefix_count;
    logic                table_full;
  } out_item_t;

  // How the final item of a word is reported.
  typedef enum logic [1:0] {
    RES_STORE,
    RES_WORD,
    RES_PREFIX
  } res_kind_e;

  // A classified item as queued between the front and back ends.
  typedef struct packed {
    logic                 do_step;
    logic                 sym_ok;
    logic                 is_insert;
    logic [SYM_IDX_W-1:0] sym;
    logic                 last;
    res_kind_e            res;
  } op_t;

  // Queue head seen by the back end.
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  // Back end control toward the front end.
  typedef struct packed {
    logic pop;
    logic busy;
  } back_ctl_t;

  // One child slot of a node row: the child pointer, the prefix count of
  // that child and its end-of-word mark.
  typedef struct packed {
    logic                  word_end;
    logic [COUNT_BITS-1:0] count;
    logic [NODE_W-1:0]     child;
  } entry_t;

  typedef entry_t [ALPHABET-1:0] row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } back_state_e;

endpackage

// ===== rtl/core/trie_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module trie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/trie_front.sv =====
// Front end: accepts input beats, classifies them and queues them.
// Depends on trie_pkg.
module trie_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  trie_pkg::in_item_t  in_item_i,
  input  trie_pkg::back_ctl_t ctl_i,
  output trie_pkg::q_head_t   head_o
);
  import trie_pkg::*;

  op_t               op;
  op_t               slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  // Classify the incoming beat.
  always_comb begin
    op.do_step   = in_item_i.has_symbol;
    op.sym_ok    = (32'(in_item_i.symbol) < ALPHABET);
    op.is_insert = (in_item_i.kind == KIND_INSERT);
    op.sym       = SYM_IDX_W'(in_item_i.symbol);
    op.last      = in_item_i.last;
    unique case (in_item_i.kind)
      KIND_INSERT: op.res = RES_STORE;
      KIND_SEARCH: op.res = RES_WORD;
      default:     op.res = RES_PREFIX;
    endcase
  end

  // Hold input off while the back end clears memory or the queue is full.
  assign in_stall_o = ctl_i.busy || (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = ctl_i.pop;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = slots_q[rd_q];

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_q] <= op;
    end
  end

endmodule

// ===== rtl/core/trie_back.sv =====
// Back end: walks the trie one letter at a time against the node-row RAM
// and drives the result register. Depends on trie_pkg and trie_ram.
module trie_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trie_pkg::q_head_t   head_i,
  output trie_pkg::back_ctl_t ctl_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output trie_pkg::out_item_t out_item_o
);
  import trie_pkg::*;

  back_state_e          state_q, state_d;
  logic [NODE_W-1:0]    clr_q, clr_d;
  logic [NODE_W-1:0]    cur_q, cur_d;
  logic [NODE_W-1:0]    used_q, used_d;
  logic                 miss_q, miss_d;
  logic                 full_q, full_d;
  logic                 root_end_q, root_end_d;
  row_t                 row_q, row_d;
  logic [NODE_W-1:0]    par_q, par_d;
  logic [SYM_IDX_W-1:0] par_sym_q, par_sym_d;
  op_t                  op_q, op_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                 we, re;
  logic [NODE_W-1:0]    waddr, raddr;
  row_t                 wdata, rdata;
  logic                 out_free;

  // Node rows: one child slot per letter.
  trie_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODES)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Next state, walk step and word finish.
  always_comb begin : comb_next
    op_t                   op;
    entry_t                e;
    entry_t                fe;
    logic                  fin;
    logic                  at_root;
    logic [COUNT_BITS-1:0] cnt;

    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    used_d      = used_q;
    miss_d      = miss_q;
    full_d      = full_q;
    root_end_d  = root_end_q;
    row_d       = row_q;
    par_d       = par_q;
    par_sym_d   = par_sym_q;
    op_d        = op_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = cur_q;
    wdata       = row_q;
    re          = 1'b0;
    raddr       = cur_q;
    ctl_o.pop   = 1'b0;
    ctl_o.busy  = (state_q == ST_CLEAR);
    op          = head_i.op;
    e           = rdata[op_q.sym];
    fe          = row_q[par_sym_q];
    fin         = 1'b0;
    at_root     = 1'b0;
    cnt         = '0;

    unique case (state_q)
      // Zero one row per cycle after reset.
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end
      end

      // Take the next queued item: a real step reads the current row,
      // anything else finishes here.
      ST_IDLE: begin
        if (head_i.valid) begin
          if (op.do_step && !miss_q && op.sym_ok) begin
            ctl_o.pop = 1'b1;
            re        = 1'b1;
            raddr     = cur_q;
            op_d      = op;
            state_d   = ST_EXEC;
          end else if (!op.last || out_free) begin
            ctl_o.pop = 1'b1;
            if (op.do_step) begin
              miss_d = 1'b1;
            end
            fin = op.last;
          end
        end
      end

      // Row data is here: follow or allocate the child.
      ST_EXEC: begin
        op = op_q;
        if (!op_q.last || out_free) begin
          state_d = ST_IDLE;
          fin     = op_q.last;
          row_d   = rdata;
          if (op_q.is_insert) begin
            if (e.child == '0) begin
              if (used_q > LAST_FREE) begin
                full_d = 1'b1;
                miss_d = 1'b1;
              end else begin
                used_d     = used_q + 1'b1;
                e.child    = used_q + 1'b1;
                e.count    = COUNT_BITS'(1);
                e.word_end = 1'b0;
              end
            end else if (e.count != COUNT_MAX) begin
              e.count = e.count + 1'b1;
            end
            if (!miss_d) begin
              row_d[op_q.sym] = e;
              we              = 1'b1;
              waddr           = cur_q;
              wdata           = row_d;
              cur_d           = e.child;
              par_d           = cur_q;
              par_sym_d       = op_q.sym;
            end
          end else if (e.child == '0) begin
            miss_d = 1'b1;
          end else begin
            cur_d     = e.child;
            par_d     = cur_q;
            par_sym_d = op_q.sym;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Final item of a word: report, mark the end on insert, go back to root.
    if (fin) begin
      at_root = (cur_d == ROOT_NODE);
      fe      = row_d[par_sym_d];
      out_d.found        = 1'b0;
      out_d.prefix_count = '0;
      out_d.table_full   = full_d;
      if (!miss_d) begin
        cnt                = at_root ? '0 : fe.count;
        out_d.prefix_count = PCOUNT_W'(cnt);
        unique case (op.res)
          RES_STORE: begin
            out_d.found = 1'b1;
            if (at_root) begin
              root_end_d = 1'b1;
            end else begin
              row_d[par_sym_d].word_end = 1'b1;
              we    = 1'b1;
              waddr = par_d;
              wdata = row_d;
            end
          end
          RES_WORD:   out_d.found = at_root ? root_end_q : fe.word_end;
          RES_PREFIX: out_d.found = (cnt != '0);
          default:    out_d.found = 1'b0;
        endcase
      end
      out_valid_d = 1'b1;
      cur_d       = ROOT_NODE;
      miss_d      = 1'b0;
      full_d      = 1'b0;
    end
  end

  // Control and walk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_q       <= ROOT_NODE;
      used_q      <= ROOT_NODE;
      miss_q      <= 1'b0;
      full_q      <= 1'b0;
      root_end_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      miss_q      <= miss_d;
      full_q      <= full_d;
      root_end_q  <= root_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    par_q     <= par_d;
    par_sym_q <= par_sym_d;
    op_q      <= op_d;
    out_q     <= out_d;
  end

endmodule

// ===== rtl/core/trie_insert_lookup.sv =====
// Array trie with insert, exact search and prefix test, one letter a beat.
// A letter passes the back end's row read, then its update; a beat that takes
// no step (no letter, a letter outside the alphabet or a letter after a miss)
// is handled as it leaves the queue. A result is valid the cycle after the final
// beat of a word executes. The back end takes no new letter until the
// read-modify-write of the node-row RAM for the last one is done. After reset a
// clearing pass, one node row a cycle over every row, stalls the input.
module trie_insert_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  trie_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output trie_pkg::out_item_t out_item_o
);
  import trie_pkg::*;

  q_head_t   head;
  back_ctl_t ctl;

  trie_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .ctl_i      (ctl),
    .head_o     (head)
  );

  trie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .ctl_o       (ctl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // No beat is taken while the memory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl.busy |-> in_stall_o)
    else $error("input accepted during clearing pass");

  // The back end only pops a queue that holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl.pop |-> head.valid)
    else $error("pop from empty queue");

  // An insert that ran out of nodes never reports the word as stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.table_full && out_item_o.found))
    else $error("full table reported with found set");

  // The clearing pass runs once after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(ctl.busy) |=> !ctl.busy)
    else $error("clearing pass restarted");

endmodule

// ===== tb/trie_checker.sv =====
// Scoreboard for the array trie: watches both beat channels and predicts each result.
// Keeps its own copy of the trie and compares each result beat field by field.
// Depends on trie_pkg for the beat types and the table sizes.
module trie_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  trie_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  trie_pkg::out_item_t out_item_i,
  output int                  mismatches_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import trie_pkg::*;

  localparam int PRINT_LIMIT = 100;

  // Shadow trie: child pointers per node and letter, end marks and pass counts.
  logic [NODE_W-1:0]     child_of   [NODES*ALPHABET];
  logic                  end_mark   [NODES];
  logic [COUNT_BITS-1:0] pass_count [NODES];

  // Walk state of the word in flight.
  logic [NODE_W-1:0] cur_node;
  int unsigned       nodes_taken;
  logic              walk_lost;
  logic              ran_out;

  // Results owed by the block, oldest first.
  out_item_t word_results [$];

  initial mismatches_o = 0;
  initial pending_o = 0;

  // One line per mismatch; only the first ones are printed.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches_o < PRINT_LIMIT)
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatches_o++;
  endtask

  // Take one letter step from the current node.
  task automatic walk_letter(input logic [KIND_W-1:0] op, input logic [SYMBOL_W-1:0] sym);
    int unsigned       slot;
    logic [NODE_W-1:0] nxt;
    if (walk_lost)
      return;
    if (sym >= ALPHABET) begin
      walk_lost = 1'b1;
      return;
    end
    slot = cur_node * ALPHABET + sym;
    nxt = child_of[slot];
    if (op == KIND_INSERT) begin
      if (nxt == '0) begin
        // The table keeps one node spare; running into it aborts the insert.
        if (nodes_taken + 1 >= NODES) begin
          ran_out = 1'b1;
          walk_lost = 1'b1;
          return;
        end
        nodes_taken++;
        nxt = NODE_W'(nodes_taken);
        child_of[slot] = nxt;
      end
      cur_node = nxt;
      if (pass_count[nxt] != COUNT_MAX)
        pass_count[nxt] = pass_count[nxt] + 1'b1;
    end else begin
      if (nxt == '0) begin
        walk_lost = 1'b1;
        return;
      end
      cur_node = nxt;
    end
  endtask

  // Apply one input beat; a final beat yields the word's result.
  task automatic trie_step(input in_item_t beat, output logic produced, output out_item_t res);
    produced = 1'b0;
    res = '0;
    if (beat.has_symbol)
      walk_letter(beat.kind, beat.symbol);
    if (beat.last) begin
      produced = 1'b1;
      if (!walk_lost) begin
        res.prefix_count = pass_count[cur_node];
        if (beat.kind == KIND_INSERT) begin
          end_mark[cur_node] = 1'b1;
          res.found = 1'b1;
        end else if (beat.kind == KIND_SEARCH) begin
          res.found = end_mark[cur_node];
        end else begin
          res.found = (pass_count[cur_node] != '0);
        end
      end
      res.table_full = ran_out;
      cur_node = ROOT_NODE;
      walk_lost = 1'b0;
      ran_out = 1'b0;
    end
  endtask

  // Results are checked before new beats are predicted, so a result can never
  // be matched against an expectation raised at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    logic      produced;
    out_item_t want;
    out_item_t res;
    if (!rst_ni) begin
      foreach (child_of[i]) child_of[i] = '0;
      foreach (end_mark[i]) end_mark[i] = 1'b0;
      foreach (pass_count[i]) pass_count[i] = '0;
      cur_node = ROOT_NODE;
      nodes_taken = 1;
      walk_lost = 1'b0;
      ran_out = 1'b0;
      word_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (word_results.size() == 0) begin
          report_mismatch("result beat with no word pending", 32'(out_item_i), '0);
        end else begin
          want = word_results.pop_front();
          if (out_item_i.found !== want.found)
            report_mismatch("found", 32'(out_item_i.found), 32'(want.found));
          if (out_item_i.prefix_count !== want.prefix_count)
            report_mismatch("prefix_count", 32'(out_item_i.prefix_count),
                            32'(want.prefix_count));
          if (out_item_i.table_full !== want.table_full)
            report_mismatch("table_full", 32'(out_item_i.table_full),
                            32'(want.table_full));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        trie_step(in_item_i, produced, res);
        if (produced)
          word_results.push_back(res);
      end
    end
    pending_o = word_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the array trie testbench: clock, reset, beat stimulus and verdict.
// Drives trie_insert_lookup and leaves all prediction to trie_checker.
// Depends on trie_pkg and trie_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trie_pkg::*;

  // Kinds that the package does not name.
  localparam logic [KIND_W-1:0] KIND_PREFIX = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_ODD    = KIND_W'(3);

  localparam logic [SYMBOL_W-1:0] LTR_A = SYMBOL_W'(0);
  localparam logic [SYMBOL_W-1:0] LTR_B = SYMBOL_W'(1);
  localparam logic [SYMBOL_W-1:0] LTR_C = SYMBOL_W'(2);
  localparam logic [SYMBOL_W-1:0] LTR_Y = SYMBOL_W'(24);
  localparam logic [SYMBOL_W-1:0] LTR_Z = SYMBOL_W'(25);
  localparam logic [SYMBOL_W-1:0] SYM_TOP = {SYMBOL_W{1'b1}};

  localparam int RANDOM_BEATS   = 1400;
  localparam int TAIL_WORDS     = 40;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int CYCLE_LIMIT    = 3000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int mismatch_count;
  int pending;
  int cycle_count;
  int hold_asks;
  int holds_served;
  logic calm;

  trie_insert_lookup DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  trie_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .mismatches_o (mismatch_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly no idling, some short gaps, a few long ones.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Letters lean on a small alphabet so that searches find stored words.
  function automatic logic [SYMBOL_W-1:0] pick_letter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88)
      return SYMBOL_W'($urandom_range(0, 3));
    if (r < 97)
      return SYMBOL_W'($urandom_range(0, ALPHABET - 1));
    return SYMBOL_W'($urandom_range(ALPHABET, 31));
  endfunction

  function automatic in_item_t make_beat(input logic [KIND_W-1:0] op,
                                         input logic [SYMBOL_W-1:0] sym,
                                         input logic has, input logic fin);
    in_item_t b;
    b.kind = op;
    b.symbol = sym;
    b.has_symbol = has;
    b.last = fin;
    return b;
  endfunction

  // Result side: random stall runs, plus one long hold on request.
  initial begin : result_drain
    int run;
    out_stall = 1'b0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_asks) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        run = pick_idle() + 1;
        repeat (run) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one beat, hold it until accepted, then maybe idle.
  task automatic send_beat(input in_item_t beat);
    int gap;
    in_valid <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = calm ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering until every owed result has come back.
  task automatic drain_results();
    if (in_valid)
      in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A random word: mostly well formed, with some mixed kinds, skipped letters,
  // letters outside the alphabet and empty words.
  task automatic send_random_word(inout int beats);
    int r;
    int len;
    logic [KIND_W-1:0] op;
    in_item_t b;
    r = $urandom_range(0, 99);
    if (r < 45)
      op = KIND_INSERT;
    else if (r < 72)
      op = KIND_SEARCH;
    else if (r < 96)
      op = KIND_PREFIX;
    else
      op = KIND_ODD;
    r = $urandom_range(0, 99);
    if (r < 4)
      len = 0;
    else if (r < 80)
      len = $urandom_range(1, 4);
    else
      len = $urandom_range(5, 8);
    if (len == 0) begin
      send_beat(make_beat(op, SYMBOL_W'($urandom_range(0, 31)), 1'b0, 1'b1));
      beats++;
      return;
    end
    for (int i = 0; i < len; i++) begin
      b = make_beat(op, pick_letter(), 1'b1, i == len - 1);
      if ($urandom_range(0, 99) < 5)
        b.kind = KIND_W'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 3) begin
        b.has_symbol = 1'b0;
        b.symbol = SYMBOL_W'($urandom_range(0, 31));
      end
      send_beat(b);
      if (b.has_symbol || b.last)
        beats++;
    end
  endtask

  initial begin : stimulus
    int beats;
    int word_no;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    calm = 1'b0;
    hold_asks = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words on an empty trie.
    // Empty prefix and empty search: the root is never counted and not yet marked.
    send_beat(make_beat(KIND_PREFIX, LTR_A, 1'b0, 1'b1));
    send_beat(make_beat(KIND_SEARCH, SYM_TOP, 1'b0, 1'b1));
    // Insert "ab" and "az", then search "ab" and "a" and test "a" as a prefix.
    send_beat(make_beat(KIND_INSERT, LTR_A, 1'b1, 1'b0));
    send_beat(make_beat(KIND_INSERT, LTR_B, 1'b1, 1'b1));
    send_beat(make_beat(KIND_INSERT, LTR_A, 1'b1, 1'b0));
    send_beat(make_beat(KIND_INSERT, LTR_Z, 1'b1, 1'b1));
    send_beat(make_beat(KIND_SEARCH, LTR_A, 1'b1, 1'b0));
    send_beat(make_beat(KIND_SEARCH, LTR_B, 1'b1, 1'b1));
    send_beat(make_beat(KIND_SEARCH, LTR_A, 1'b1, 1'b1));
    send_beat(make_beat(KIND_PREFIX, LTR_A, 1'b1, 1'b1));
    send_beat(make_beat(KIND_ODD, LTR_A, 1'b1, 1'b1));
    // Missing child on a search.
    send_beat(make_beat(KIND_SEARCH, LTR_A, 1'b1, 1'b0));
    send_beat(make_beat(KIND_SEARCH, LTR_C, 1'b1, 1'b1));
    // Letters outside the alphabet fail the word.
    send_beat(make_beat(KIND_INSERT, SYM_TOP, 1'b1, 1'b1));
    send_beat(make_beat(KIND_PREFIX, SYMBOL_W'(ALPHABET), 1'b1, 1'b1));
    // Mixed kinds: the final beat's kind decides the result.
    send_beat(make_beat(KIND_INSERT, LTR_B, 1'b1, 1'b0));
    send_beat(make_beat(KIND_SEARCH, LTR_C, 1'b1, 1'b1));
    // A beat without a letter in the middle takes no step.
    send_beat(make_beat(KIND_SEARCH, LTR_A, 1'b1, 1'b0));
    send_beat(make_beat(KIND_SEARCH, SYM_TOP, 1'b0, 1'b0));
    send_beat(make_beat(KIND_SEARCH, LTR_B, 1'b1, 1'b1));
    // The empty word marks the root.
    send_beat(make_beat(KIND_INSERT, SYM_TOP, 1'b0, 1'b1));
    send_beat(make_beat(KIND_SEARCH, LTR_A, 1'b0, 1'b1));

    // Random words, with stretches of no idling, one long result hold
    // and a few full drains.
    beats = 0;
    word_no = 0;
    while (beats < RANDOM_BEATS) begin
      word_no++;
      calm = (word_no % 200) < 30;
      if (word_no == 150)
        hold_asks++;
      if (word_no == 300 || word_no % 97 == 0)
        drain_results();
      send_random_word(beats);
    end
    drain_results();
    calm = 1'b0;

    // A last batch of words, then a search through rarely used letters.
    beats = 0;
    repeat (TAIL_WORDS) send_random_word(beats);
    send_beat(make_beat(KIND_SEARCH, LTR_Z, 1'b1, 1'b0));
    send_beat(make_beat(KIND_SEARCH, LTR_Y, 1'b1, 1'b1));

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
